// ===== rtl/isd_pkg.sv =====
package isd_pkg;

    localparam int unsigned DeltaW = 24;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned MsW    = 16;
    localparam int unsigned RunW   = 4;
    localparam int unsigned IdxW   = 2;

    typedef enum logic [IdxW-1:0] {
        REG_EXIT_TIMEOUT = 2'd0,
        REG_BUILD_WINDOW = 2'd1,
        REG_RUN_LENGTH   = 2'd2
    } t_reg_idx;

    localparam logic [MsW-1:0]  ExitTimeoutReset = 16'd100;
    localparam logic [MsW-1:0]  BuildWindowReset = 16'd80;
    localparam logic [RunW-1:0] RunLengthReset   = 4'd4;
    localparam logic [RunW-1:0] RunLengthMin     = 4'd2;

    typedef struct packed {
        logic [MsW-1:0]  exit_timeout_ms;
        logic [MsW-1:0]  build_window_ms;
        logic [RunW-1:0] run_length;
    } t_cfg;

    typedef struct packed {
        logic              inertia_active;
        logic [RunW-1:0]   run_count;
        logic [DeltaW-1:0] last_magnitude;
        logic              last_positive;
        logic [TimeW-1:0]  last_time;
    } t_state;

    localparam t_state StateReset = '{
        inertia_active: 1'b0,
        run_count:      '0,
        last_magnitude: '0,
        last_positive:  1'b1,
        last_time:      '0
    };

endpackage

// ===== rtl/isd_classify.sv =====
module isd_classify (
    input  isd_pkg::t_cfg                     i_cfg,
    input  isd_pkg::t_state                   i_state,
    input  logic signed [isd_pkg::DeltaW-1:0] i_delta,
    input  logic [isd_pkg::TimeW-1:0]         i_timestamp_ms,
    output isd_pkg::t_state                   o_state,
    output logic                              o_is_inertial
);

    logic                          pos;
    logic [isd_pkg::DeltaW-1:0]    mag;
    logic [isd_pkg::TimeW-1:0]     gap;
    logic                          same_dir;
    logic                          shrinks;
    logic [isd_pkg::RunW-1:0]      count_inc;
    logic [isd_pkg::RunW-1:0]      target;
    isd_pkg::t_state               restart;

    always_comb begin
        pos      = ~i_delta[isd_pkg::DeltaW-1];
        // most negative delta negates to 2^23, still fits unsigned
        mag      = pos ? i_delta : (~i_delta + 1'b1);
        gap      = i_timestamp_ms - i_state.last_time;
        same_dir = (pos == i_state.last_positive);
        shrinks  = (mag < i_state.last_magnitude);
        count_inc = i_state.run_count + 1'b1;
        target   = (i_cfg.run_length < isd_pkg::RunLengthMin) ?
                   isd_pkg::RunLengthMin : i_cfg.run_length;

        restart.inertia_active = 1'b0;
        restart.run_count      = {{(isd_pkg::RunW-1){1'b0}}, 1'b1};
        restart.last_magnitude = mag;
        restart.last_positive  = pos;
        restart.last_time      = i_timestamp_ms;

        o_state       = i_state;
        o_is_inertial = 1'b0;

        if (i_delta == '0) begin
            o_is_inertial = 1'b1;
        end else if (i_state.inertia_active) begin
            if (!same_dir || !shrinks ||
                gap > {{(isd_pkg::TimeW-isd_pkg::MsW){1'b0}}, i_cfg.exit_timeout_ms}) begin
                o_state = restart;
            end else begin
                o_state.last_time = i_timestamp_ms;
                o_is_inertial     = 1'b1;
            end
        end else if (i_state.run_count != '0 && same_dir && shrinks &&
                     gap <= {{(isd_pkg::TimeW-isd_pkg::MsW){1'b0}},
                             i_cfg.build_window_ms}) begin
            o_state.last_magnitude = mag;
            o_state.last_time      = i_timestamp_ms;
            o_state.run_count      = count_inc;
            if (count_inc == target) begin
                o_state.inertia_active = 1'b1;
                o_is_inertial          = 1'b1;
            end
        end else begin
            o_state = restart;
        end
    end

endmodule

// ===== rtl/inertia_scroll_detector.sv =====
// Scroll inertia classifier. Takes one event per clock when the output is not
// stalled and returns one is_inertial flag per event. The flag is held in the
// result register while the output is stalled. Events pass an input register,
// then the combinational compare/update logic writes the tracking state and the
// result register in the same clock, so the next event sees the updated state at
// once. A zero delta always reports inertial and leaves the state alone.
// Config writes are registered and must only be issued while idle.
module inertia_scroll_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [isd_pkg::IdxW-1:0]          i_cfg_index,
    input  logic [isd_pkg::MsW-1:0]           i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [isd_pkg::DeltaW-1:0] i_delta,
    input  logic [isd_pkg::TimeW-1:0]         i_timestamp_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_is_inertial
);

    isd_pkg::t_cfg                   r_cfg;
    isd_pkg::t_state                 r_state;
    isd_pkg::t_state                 n_state;
    logic                            r_in_valid;
    logic signed [isd_pkg::DeltaW-1:0] r_delta;
    logic [isd_pkg::TimeW-1:0]       r_timestamp_ms;
    logic                            r_out_valid;
    logic                            r_is_inertial;
    logic                            n_is_inertial;
    logic                            advance;
    logic                            in_accept;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_is_inertial = r_is_inertial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exit_timeout_ms <= isd_pkg::ExitTimeoutReset;
            r_cfg.build_window_ms <= isd_pkg::BuildWindowReset;
            r_cfg.run_length      <= isd_pkg::RunLengthReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                isd_pkg::REG_EXIT_TIMEOUT: r_cfg.exit_timeout_ms <= i_cfg_data;
                isd_pkg::REG_BUILD_WINDOW: r_cfg.build_window_ms <= i_cfg_data;
                isd_pkg::REG_RUN_LENGTH:
                    r_cfg.run_length <= i_cfg_data[isd_pkg::RunW-1:0];
                default: ;
            endcase
        end
    end

    isd_classify u_classify (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_delta        (r_delta),
        .i_timestamp_ms (r_timestamp_ms),
        .o_state        (n_state),
        .o_is_inertial  (n_is_inertial)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= isd_pkg::StateReset;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_delta        <= i_delta;
            r_timestamp_ms <= i_timestamp_ms;
        end
        if (advance && r_in_valid) begin
            r_is_inertial <= n_is_inertial;
        end
    end

endmodule

// ===== rtl/isd_checker.sv =====
module isd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic signed [isd_pkg::DeltaW-1:0] i_delta,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_is_inertial
);

    logic in_accept;
    assign in_accept = i_in_valid && !o_in_stall;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_is_inertial))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output can drain");

    a_zero_inertial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_delta == '0 ##1 !i_out_stall |=> o_out_valid && o_is_inertial)
        else $error("zero delta not reported inertial");

endmodule

bind inertia_scroll_detector isd_checker u_isd_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int unsigned CycleLimit = 400000;
    localparam logic [isd_pkg::IdxW-1:0] RegSpare = 2'd3;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [isd_pkg::IdxW-1:0]          i_cfg_index = '0;
    logic [isd_pkg::MsW-1:0]           i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic signed [isd_pkg::DeltaW-1:0] i_delta = '0;
    logic [isd_pkg::TimeW-1:0]         i_timestamp_ms = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic                              o_is_inertial;

    // predictor copy of the block's registers and tracking state
    isd_pkg::t_cfg   cfg = '{isd_pkg::ExitTimeoutReset, isd_pkg::BuildWindowReset,
                             isd_pkg::RunLengthReset};
    isd_pkg::t_state trk = isd_pkg::StateReset;

    bit                        pending_inertial[$];
    int unsigned               events_sent = 0;
    int unsigned               mismatches = 0;
    int unsigned               cycle_count = 0;
    int unsigned               hold_cycles = 0;
    bit                        no_idle = 1'b0;
    logic [isd_pkg::TimeW-1:0] ms_clock = '0;

    inertia_scroll_detector u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_delta        (i_delta),
        .i_timestamp_ms (i_timestamp_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_inertial  (o_is_inertial)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit classify_scroll(input logic [isd_pkg::DeltaW-1:0] d,
                                           input logic [isd_pkg::TimeW-1:0] t);
        logic                        pos;
        logic [isd_pkg::DeltaW-1:0]  mag;
        logic [isd_pkg::TimeW-1:0]   gap;
        logic [isd_pkg::RunW-1:0]    target;
        logic [isd_pkg::TimeW-1:0]   exit_lim;
        logic [isd_pkg::TimeW-1:0]   build_lim;
        if (d == '0)
            return 1'b1;
        pos       = ~d[isd_pkg::DeltaW-1];
        mag       = pos ? d : ~d + 1'b1;
        gap       = t - trk.last_time;
        exit_lim  = {{(isd_pkg::TimeW-isd_pkg::MsW){1'b0}}, cfg.exit_timeout_ms};
        build_lim = {{(isd_pkg::TimeW-isd_pkg::MsW){1'b0}}, cfg.build_window_ms};
        target    = (cfg.run_length < isd_pkg::RunLengthMin) ? isd_pkg::RunLengthMin
                                                             : cfg.run_length;
        if (trk.inertia_active) begin
            // staying in inertia only moves the time; magnitude stays frozen
            if (pos == trk.last_positive && mag < trk.last_magnitude &&
                gap <= exit_lim) begin
                trk.last_time = t;
                return 1'b1;
            end
            trk.inertia_active = 1'b0;
        end else if (trk.run_count != '0 && pos == trk.last_positive &&
                     mag < trk.last_magnitude && gap <= build_lim) begin
            trk.last_magnitude = mag;
            trk.last_time      = t;
            trk.run_count      = trk.run_count + 1'b1;
            trk.inertia_active = (trk.run_count == target);
            return trk.inertia_active;
        end
        trk.run_count      = 4'd1;
        trk.last_magnitude = mag;
        trk.last_positive  = pos;
        trk.last_time      = t;
        return 1'b0;
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side: random stalls, plus a forced hold-off when requested
    initial begin : out_side
        int unsigned left;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else if (no_idle) begin
                i_out_stall <= 1'b0;
                left = 0;
            end else if (left != 0) begin
                left--;
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                left = pick_idle();
            end else begin
                i_out_stall <= 1'b0;
                left = $urandom_range(0, 8);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        bit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_inertial.size() == 0) begin
                $error("is_inertial: result with no request pending, got %0b",
                       o_is_inertial);
                mismatches++;
            end else begin
                want = pending_inertial.pop_front();
                if (o_is_inertial !== want) begin
                    $error("is_inertial: expected %0b, got %0b", want, o_is_inertial);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_event(input logic [isd_pkg::DeltaW-1:0] d,
                              input logic [isd_pkg::TimeW-1:0] t);
        int unsigned idle;
        idle = pick_idle();
        @(negedge i_clk);
        if (idle != 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_delta        <= d;
        i_timestamp_ms <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_inertial.push_back(classify_scroll(d, t));
        events_sent++;
    endtask

    task automatic scroll_after(input logic [isd_pkg::TimeW-1:0] gap,
                                input logic [isd_pkg::DeltaW-1:0] d);
        ms_clock = ms_clock + gap;
        send_event(d, ms_clock);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_inertial.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [isd_pkg::IdxW-1:0] idx,
                             input logic [isd_pkg::MsW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            isd_pkg::REG_EXIT_TIMEOUT: cfg.exit_timeout_ms = data;
            isd_pkg::REG_BUILD_WINDOW: cfg.build_window_ms = data;
            isd_pkg::REG_RUN_LENGTH:   cfg.run_length      = data[isd_pkg::RunW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [isd_pkg::MsW-1:0] exit_ms,
                              input logic [isd_pkg::MsW-1:0] window_ms,
                              input logic [isd_pkg::MsW-1:0] run_data);
        wait_idle();
        write_reg(isd_pkg::REG_EXIT_TIMEOUT, exit_ms);
        write_reg(isd_pkg::REG_BUILD_WINDOW, window_ms);
        write_reg(isd_pkg::REG_RUN_LENGTH, run_data);
    endtask

    // one flick: shrinking same-direction deltas, with some breaks mixed in
    task automatic scroll_gesture();
        logic [isd_pkg::DeltaW-1:0] mag;
        bit                         neg;
        int unsigned                n;
        int unsigned                lim;
        int unsigned                roll;
        int unsigned                step;
        logic [isd_pkg::TimeW-1:0]  gap;
        neg = 1'($urandom_range(0, 1));
        mag = ($urandom_range(0, 7) == 0) ? 24'h800000
                                          : 24'($urandom_range(256, 24'h7FFFFF));
        if (!neg && mag[isd_pkg::DeltaW-1])
            mag = 24'h7FFFFF;
        lim = (cfg.exit_timeout_ms < cfg.build_window_ms) ? cfg.exit_timeout_ms
                                                          : cfg.build_window_ms;
        n = cfg.run_length + $urandom_range(1, 12);
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                gap = $urandom_range(0, lim);
                scroll_after(gap, '0);
                continue;
            end
            if (roll < 8) begin
                neg = ~neg;
                if (!neg && mag[isd_pkg::DeltaW-1])
                    mag = 24'h7FFFFF;
            end else if (roll >= 11) begin
                step = $urandom_range(1, mag / 3 + 1);
                if (step >= mag)
                    break;
                mag = mag - 24'(step);
            end
            roll = $urandom_range(0, 99);
            if (roll < 10)
                gap = lim;
            else if (roll < 88)
                gap = $urandom_range(0, lim);
            else if (roll < 97)
                gap = lim + 1 + $urandom_range(0, 300);
            else
                gap = $urandom;
            scroll_after(gap, neg ? ~mag + 1'b1 : mag);
        end
    endtask

    task automatic run_random_items(input int unsigned count);
        int unsigned stop_at;
        stop_at = events_sent + count;
        while (events_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                ms_clock = $urandom;
                send_event(24'($urandom), ms_clock);
            end else begin
                no_idle = ($urandom_range(0, 7) == 0);
                scroll_gesture();
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_directed_defaults();
        // timestamps start just below the wrap point
        ms_clock = 32'hFFFF_FF80;
        scroll_after(0, '0);
        scroll_after(10, 24'h7FFFFF);       // first nonzero event
        scroll_after(80, 24'd4000);         // gap equal to build window
        scroll_after(1, 24'd3000);
        scroll_after(0, 24'd2000);          // enters inertia
        scroll_after(100, 24'd1000);        // gap equal to exit timeout
        scroll_after(5, 24'd1500);          // still below the frozen magnitude
        scroll_after(0, '0);
        scroll_after(5, 24'd2000);          // magnitude not shrinking: leave
        scroll_after(5, 24'd1900);
        scroll_after(5, 24'd1800);
        scroll_after(5, 24'd1700);
        scroll_after(5, -24'sd100);         // direction change: leave
        scroll_after(81, 24'h800000);       // most negative, after a too-long gap
        scroll_after(3, 24'h800001);
        scroll_after(3, -24'sd300);
        scroll_after(3, -24'sd200);
        scroll_after(101, -24'sd100);       // gap past exit timeout: leave
        scroll_after(2, -24'sd50);
        send_event(24'h7FFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_register_extremes();
        set_config(16'd0, 16'd0, 16'd0);            // run length zero acts as two
        run_random_items(40);
        set_config(16'hFFFF, 16'hFFFF, 16'd1);
        run_random_items(40);
        set_config(16'd1, 16'd2, 16'hFFFF);
        write_reg(RegSpare, 16'h5A5A);              // out of range: ignored
        run_random_items(60);
    endtask

    task automatic test_output_holdoff();
        int unsigned stop_at;
        stop_at = events_sent + 40;
        set_config(16'd200, 16'd150, 16'd3);
        no_idle     = 1'b1;
        hold_cycles = 150;
        while (events_sent < stop_at)
            scroll_gesture();
        no_idle = 1'b0;
    endtask

    task automatic test_random_settings();
        logic [isd_pkg::MsW-1:0] exit_ms;
        logic [isd_pkg::MsW-1:0] window_ms;
        repeat (5) begin
            exit_ms   = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 250));
            window_ms = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 250));
            set_config(exit_ms, window_ms, 16'($urandom));
            if ($urandom_range(0, 1) == 0)
                ms_clock = 32'hFFFF_F000;
            run_random_items(140);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_defaults();
        test_register_extremes();
        test_output_holdoff();
        test_random_settings();
        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
